FILE: rtl/spi_pkg.sv
package spi_pkg;

    // Quotient bits that the divider produces, and the clamp on the offset.
    localparam int QUOT_BITS = 42;
    localparam int CAP_LOG   = 40;

    // Width of the signed sum of start point and offset before saturation.
    localparam int SUM_BITS  = 44;

    // Register stages of one placement pipe: magnitudes, two partial products,
    // their sum, the divider set-up, one stage per quotient bit and the final sum.
    localparam int PLACE_LAT = QUOT_BITS + 5;

    // Decisions made for one segment pair.
    typedef struct packed {
        logic par;
        logic meet;
        logic same;
        logic both;
    } t_flags;

endpackage

FILE: rtl/spi_in_if.sv
interface spi_in_if #(
    parameter int COORD_BITS = 24
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] first_start_x;
    logic signed [COORD_BITS-1:0] first_start_y;
    logic signed [COORD_BITS-1:0] first_dir_x;
    logic signed [COORD_BITS-1:0] first_dir_y;
    logic signed [COORD_BITS-1:0] second_start_x;
    logic signed [COORD_BITS-1:0] second_start_y;
    logic signed [COORD_BITS-1:0] second_dir_x;
    logic signed [COORD_BITS-1:0] second_dir_y;

    modport source (
        output valid, first_start_x, first_start_y, first_dir_x, first_dir_y,
               second_start_x, second_start_y, second_dir_x, second_dir_y,
        input  ready
    );
    modport sink (
        input  valid, first_start_x, first_start_y, first_dir_x, first_dir_y,
               second_start_x, second_start_y, second_dir_x, second_dir_y,
        output ready
    );
endinterface

FILE: rtl/spi_out_if.sv
interface spi_out_if #(
    parameter int COORD_BITS = 24
);
    logic                         valid;
    logic                         ready;
    logic                         lines_meet;
    logic                         same_line;
    logic                         on_both_segments;
    logic signed [COORD_BITS-1:0] cross_x;
    logic signed [COORD_BITS-1:0] cross_y;
    logic                         point_saturated;

    modport source (
        output valid, lines_meet, same_line, on_both_segments, cross_x, cross_y,
               point_saturated,
        input  ready
    );
    modport sink (
        input  valid, lines_meet, same_line, on_both_segments, cross_x, cross_y,
               point_saturated,
        output ready
    );
endinterface

FILE: rtl/spi_front.sv
module spi_front #(
    parameter int C  = 24,
    parameter int NW = 50
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    spi_in_if.sink               i_item,
    output logic                 o_valid,
    output spi_pkg::t_flags      o_flags,
    output logic signed [C-1:0]  o_ax,
    output logic signed [C-1:0]  o_ay,
    output logic signed [C-1:0]  o_d1x,
    output logic signed [C-1:0]  o_d1y,
    output logic signed [NW-1:0] o_den,
    output logic signed [NW-1:0] o_tnum
);
    import spi_pkg::*;

    localparam int PW = C + 1;
    localparam int FW = 2 * C + 2;

    // Parameter num/den lies in the closed unit interval; den is nonzero.
    function automatic logic f_unit(input logic signed [NW-1:0] num,
                                    input logic signed [NW-1:0] den);
        logic res;
        if (den > 0) begin
            res = (num >= 0) && (num <= den);
        end else begin
            res = (num <= 0) && (num >= den);
        end
        return res;
    endfunction

    logic                 r1_v, r2_v, r3_v, r4_v;
    logic signed [C-1:0]  r1_ax, r1_ay, r1_d1x, r1_d1y, r1_d2x, r1_d2y;
    logic signed [PW-1:0] r1_px, r1_py;

    logic signed [C-1:0]     r2_ax, r2_ay, r2_d1x, r2_d1y, r2_d2x, r2_d2y;
    logic signed [PW-1:0]    r2_px, r2_py;
    logic signed [2*C-1:0]   r2_da, r2_db;
    logic signed [2*C:0]     r2_ta, r2_tb, r2_ua, r2_ub;

    logic signed [C-1:0]  r3_ax, r3_ay, r3_d1x, r3_d1y, r3_d2x, r3_d2y;
    logic signed [PW-1:0] r3_px, r3_py;
    logic signed [NW-1:0] r3_den, r3_tnum, r3_unum;

    logic signed [FW-1:0] n_den, n_tnum, n_unum;
    logic                 n_inside;
    t_flags               n_flags;

    logic signed [C-1:0]  r4_ax, r4_ay, r4_d1x, r4_d1y;
    logic signed [NW-1:0] r4_den, r4_tnum;
    t_flags               r4_flags;

    assign i_item.ready = i_en;

    // Valid bits advance with the pipe.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
        end else if (i_en) begin
            r1_v <= i_item.valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
        end
    end

    // Stage one: offset between the two start points.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_ax  <= i_item.first_start_x;
            r1_ay  <= i_item.first_start_y;
            r1_d1x <= i_item.first_dir_x;
            r1_d1y <= i_item.first_dir_y;
            r1_d2x <= i_item.second_dir_x;
            r1_d2y <= i_item.second_dir_y;
            r1_px  <= PW'(i_item.first_start_x) - PW'(i_item.second_start_x);
            r1_py  <= PW'(i_item.first_start_y) - PW'(i_item.second_start_y);
        end
    end

    // Stage two: the six cross products.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_ax  <= r1_ax;
            r2_ay  <= r1_ay;
            r2_d1x <= r1_d1x;
            r2_d1y <= r1_d1y;
            r2_d2x <= r1_d2x;
            r2_d2y <= r1_d2y;
            r2_px  <= r1_px;
            r2_py  <= r1_py;
            r2_da  <= r1_d2x * r1_d1y;
            r2_db  <= r1_d2y * r1_d1x;
            r2_ta  <= r1_d2y * r1_px;
            r2_tb  <= r1_d2x * r1_py;
            r2_ua  <= r1_d1y * r1_px;
            r2_ub  <= r1_d1x * r1_py;
        end
    end

    // Stage three: denominator and the two numerators, wrapped to the working width.
    assign n_den  = FW'(r2_da) - FW'(r2_db);
    assign n_tnum = FW'(r2_ta) - FW'(r2_tb);
    assign n_unum = FW'(r2_ua) - FW'(r2_ub);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_ax   <= r2_ax;
            r3_ay   <= r2_ay;
            r3_d1x  <= r2_d1x;
            r3_d1y  <= r2_d1y;
            r3_d2x  <= r2_d2x;
            r3_d2y  <= r2_d2y;
            r3_px   <= r2_px;
            r3_py   <= r2_py;
            r3_den  <= NW'(n_den);
            r3_tnum <= NW'(n_tnum);
            r3_unum <= NW'(n_unum);
        end
    end

    // Stage four: decisions. The extent test uses x unless the second direction
    // has no x part, and a point-like second segment needs equal start points.
    always_comb begin
        if (r3_d2x == '0 && r3_d2y == '0) begin
            n_inside = (r3_px == '0) && (r3_py == '0);
        end else if (r3_d2x == '0) begin
            n_inside = f_unit(NW'(r3_py), NW'(r3_d2y));
        end else begin
            n_inside = f_unit(NW'(r3_px), NW'(r3_d2x));
        end
        n_flags.par  = (r3_den == '0);
        n_flags.same = n_flags.par && (r3_tnum == '0) && n_inside;
        n_flags.meet = !n_flags.par || n_flags.same;
        n_flags.both = !n_flags.par && f_unit(r3_tnum, r3_den) && f_unit(r3_unum, r3_den);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r4_ax    <= r3_ax;
            r4_ay    <= r3_ay;
            r4_d1x   <= r3_d1x;
            r4_d1y   <= r3_d1y;
            r4_den   <= r3_den;
            r4_tnum  <= r3_tnum;
            r4_flags <= n_flags;
        end
    end

    assign o_valid = r4_v;
    assign o_flags = r4_flags;
    assign o_ax    = r4_ax;
    assign o_ay    = r4_ay;
    assign o_d1x   = r4_d1x;
    assign o_d1y   = r4_d1y;
    assign o_den   = r4_den;
    assign o_tnum  = r4_tnum;

endmodule

FILE: rtl/spi_place.sv
module spi_place #(
    parameter int C  = 24,
    parameter int NW = 50
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic signed [C-1:0]  i_start,
    input  logic signed [C-1:0]  i_dir,
    input  logic signed [NW-1:0] i_num,
    input  logic signed [NW-1:0] i_den,
    output logic signed [C-1:0]  o_val,
    output logic                 o_sat
);
    import spi_pkg::*;

    localparam int QB  = QUOT_BITS;
    localparam int VW  = SUM_BITS;
    localparam int NH  = NW / 2;
    localparam int NHH = NW - NH;
    localparam int PRW = C + NW;
    localparam int NX  = QB + NW;
    localparam logic [QB-1:0] CAP = QB'(1) << CAP_LOG;
    localparam logic signed [VW-1:0] CMAX = VW'((64'sd1 <<< (C - 1)) - 64'sd1);
    localparam logic signed [VW-1:0] CMIN = -CMAX - VW'(1);

    // Stage A: magnitudes and the sign of the offset.
    logic                r_a_neg;
    logic [C-1:0]        r_a_am;
    logic [NW-1:0]       r_a_nm, r_a_dm;
    logic signed [C-1:0] r_a_start;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_neg   <= i_dir[C-1] ^ i_num[NW-1] ^ i_den[NW-1];
            r_a_am    <= i_dir[C-1] ? C'(-i_dir) : C'(i_dir);
            r_a_nm    <= i_num[NW-1] ? NW'(-i_num) : NW'(i_num);
            r_a_dm    <= i_den[NW-1] ? NW'(-i_den) : NW'(i_den);
            r_a_start <= i_start;
        end
    end

    // Stage B: two partial products of direction and numerator.
    logic                r_b_neg;
    logic [C+NH-1:0]     r_b_pl;
    logic [C+NHH-1:0]    r_b_ph;
    logic [NW-1:0]       r_b_dm;
    logic signed [C-1:0] r_b_start;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_b_neg   <= r_a_neg;
            r_b_pl    <= r_a_am * r_a_nm[NH-1:0];
            r_b_ph    <= r_a_am * r_a_nm[NW-1:NH];
            r_b_dm    <= r_a_dm;
            r_b_start <= r_a_start;
        end
    end

    // Stage C: full dividend.
    logic                r_c_neg;
    logic [PRW-1:0]      r_c_n;
    logic [NW-1:0]       r_c_dm;
    logic signed [C-1:0] r_c_start;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_c_neg   <= r_b_neg;
            r_c_n     <= PRW'(r_b_pl) + (PRW'(r_b_ph) << NH);
            r_c_dm    <= r_b_dm;
            r_c_start <= r_b_start;
        end
    end

    // Stage D and the divider stages: restoring division, one quotient bit per
    // stage. A dividend whose top part already reaches the divisor overflows.
    logic [NX-1:0]       n_nx;
    logic [NW-1:0]       r_rem   [QB+1];
    logic [QB-1:0]       r_low   [QB+1];
    logic [QB-1:0]       r_q     [QB+1];
    logic [NW-1:0]       r_dv    [QB+1];
    logic                r_ovf   [QB+1];
    logic                r_neg   [QB+1];
    logic signed [C-1:0] r_start [QB+1];

    assign n_nx = NX'(r_c_n);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]   <= n_nx[NX-1:QB];
            r_low[0]   <= n_nx[QB-1:0];
            r_q[0]     <= '0;
            r_dv[0]    <= r_c_dm;
            r_ovf[0]   <= (n_nx[NX-1:QB] >= r_c_dm);
            r_neg[0]   <= r_c_neg;
            r_start[0] <= r_c_start;
        end
    end

    for (genvar k = 0; k < QB; k++) begin : g_div
        logic [NW:0] w_rem2;
        logic [NW:0] w_diff;
        logic        w_ge;

        assign w_rem2 = {r_rem[k], r_low[k][QB-1]};
        assign w_diff = w_rem2 - {1'b0, r_dv[k]};
        assign w_ge   = (w_rem2 >= {1'b0, r_dv[k]});

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k+1]   <= w_ge ? w_diff[NW-1:0] : w_rem2[NW-1:0];
                r_low[k+1]   <= r_low[k] << 1;
                r_q[k+1]     <= {r_q[k][QB-2:0], w_ge};
                r_dv[k+1]    <= r_dv[k];
                r_ovf[k+1]   <= r_ovf[k];
                r_neg[k+1]   <= r_neg[k];
                r_start[k+1] <= r_start[k];
            end
        end
    end

    // Stage E: clamp the offset, add it to the start point and saturate.
    logic [QB-1:0]        n_qc;
    logic signed [VW-1:0] n_off, n_sum;
    logic                 r_e_sat;
    logic signed [C-1:0]  r_e_val;

    always_comb begin
        n_qc  = (r_ovf[QB] || r_q[QB] > CAP) ? CAP : r_q[QB];
        n_off = r_neg[QB] ? -VW'(n_qc) : VW'(n_qc);
        n_sum = VW'(r_start[QB]) + n_off;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (n_sum > CMAX) begin
                r_e_val <= C'(CMAX);
                r_e_sat <= 1'b1;
            end else if (n_sum < CMIN) begin
                r_e_val <= C'(CMIN);
                r_e_sat <= 1'b1;
            end else begin
                r_e_val <= C'(n_sum);
                r_e_sat <= 1'b0;
            end
        end
    end

    assign o_val = r_e_val;
    assign o_sat = r_e_sat;

endmodule

FILE: rtl/segment_pair_intersect.sv
// Intersection of two 2-D segments, each given as a start point and a direction
// in signed fixed point. One pair is accepted per cycle while the output is not
// stalled; each passes through a front of offset, cross products and decisions,
// then a placement pipe whose length is set by the divider, which
// resolves one quotient bit per stage. The whole pipe holds on a stalled output,
// so input ready follows output ready whenever a result is waiting.
module segment_pair_intersect #(
    parameter int COORD_BITS = 24
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    spi_in_if.sink   i_item,
    spi_out_if.source o_result
);
    import spi_pkg::*;

    localparam int NW   = (2 * COORD_BITS + 2 > 64) ? 64 : 2 * COORD_BITS + 2;
    localparam int LAST = PLACE_LAT - 1;

    logic                          w_en;
    logic                          w_fv;
    t_flags                        w_ff;
    logic signed [COORD_BITS-1:0]  w_ax, w_ay, w_d1x, w_d1y;
    logic signed [NW-1:0]          w_den, w_tnum;
    logic signed [COORD_BITS-1:0]  w_vx, w_vy;
    logic                          w_sx, w_sy;

    logic   r_vld [PLACE_LAT];
    t_flags r_flg [PLACE_LAT];

    // The pipe advances unless a finished beat is held back.
    assign w_en = !r_vld[LAST] || o_result.ready;

    spi_front #(.C(COORD_BITS), .NW(NW)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_item  (i_item),
        .o_valid (w_fv),
        .o_flags (w_ff),
        .o_ax    (w_ax),
        .o_ay    (w_ay),
        .o_d1x   (w_d1x),
        .o_d1y   (w_d1y),
        .o_den   (w_den),
        .o_tnum  (w_tnum)
    );

    spi_place #(.C(COORD_BITS), .NW(NW)) u_place_x (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_start (w_ax),
        .i_dir   (w_d1x),
        .i_num   (w_tnum),
        .i_den   (w_den),
        .o_val   (w_vx),
        .o_sat   (w_sx)
    );

    spi_place #(.C(COORD_BITS), .NW(NW)) u_place_y (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_start (w_ay),
        .i_dir   (w_d1y),
        .i_num   (w_tnum),
        .i_den   (w_den),
        .o_val   (w_vy),
        .o_sat   (w_sy)
    );

    // Valid bits and decisions travel alongside the placement pipes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < PLACE_LAT; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (w_en) begin
            r_vld[0] <= w_fv;
            for (int k = 1; k < PLACE_LAT; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_flg[0] <= w_ff;
            for (int k = 1; k < PLACE_LAT; k++) begin
                r_flg[k] <= r_flg[k-1];
            end
        end
    end

    // Parallel lines report no point.
    assign o_result.valid            = r_vld[LAST];
    assign o_result.lines_meet       = r_flg[LAST].meet;
    assign o_result.same_line        = r_flg[LAST].same;
    assign o_result.on_both_segments = r_flg[LAST].both;
    assign o_result.cross_x          = r_flg[LAST].par ? '0 : w_vx;
    assign o_result.cross_y          = r_flg[LAST].par ? '0 : w_vy;
    assign o_result.point_saturated  = !r_flg[LAST].par && (w_sx || w_sy);

    // A coincident pair carries no crossing point.
    a_same_no_point : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid && o_result.same_line |->
            o_result.lines_meet && !o_result.on_both_segments
            && !o_result.point_saturated)
        else $error("same line reported with a crossing point");

    // Lines that do not meet give a zero point and no flags.
    a_miss_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid && !o_result.lines_meet |->
            o_result.cross_x == '0 && o_result.cross_y == '0
            && !o_result.point_saturated && !o_result.on_both_segments)
        else $error("non-meeting lines gave a point");

    // Input is held off exactly when a result beat is stalled.
    a_ready_link : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_item.ready == (!o_result.valid || o_result.ready))
        else $error("input ready out of step with output stall");

    // A held result beat keeps its value.
    a_hold_point : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid && !o_result.ready |=>
            $stable(o_result.cross_x) && $stable(o_result.cross_y))
        else $error("stalled result changed");

endmodule
